@@ hdl/wrench_frame_transform_macros.svh @@
// Assertion macros for the wrench frame transform checker.
// Included by the checker file; expects signals named clock and reset in scope.
`ifndef WRENCH_FRAME_TRANSFORM_MACROS_SVH
`define WRENCH_FRAME_TRANSFORM_MACROS_SVH

// Property checked only while reset is low.
`define WFT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define WFT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/wft_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and register codes for the wrench frame transform.
// No dependencies; every module of the block imports it.
package wft_pkg;

   localparam int FIELD_W   = 32;
   localparam int NUM_FIELD = 6;
   localparam int TDATA_W   = NUM_FIELD * FIELD_W;
   localparam int COEF_W    = 36;
   localparam int VEC_W     = 50;
   localparam int SPLIT     = 24;
   localparam int VH_W      = VEC_W - SPLIT;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROT_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POS_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_POS_Z = 3'd6;

   localparam logic signed [FIELD_W-1:0] ROT_ONE = 32'sh4000_0000;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [VH_W-1:0]    vhi_type;
   typedef logic        [SPLIT-1:0]   vlo_type;

   // Load enables of the five data stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } adv_type;

endpackage

@@ hdl/wrench_frame_transform.sv @@
`timescale 1ns / 1ps
// Top level of the wrench frame transform: register file, stall control and datapath.
// Depends on wft_pkg, wft_coef, wft_front and wft_rotate.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------------
//   req     | in        | req_tvalid/tready  | force x/y/z, torque x/y/z, 32 bits each
//   rsp     | out       | rsp_tvalid/tready  | out force x/y/z, out torque x/y/z
//   csr     | in        | csr_valid/ready    | csr_index (register), csr_data (value)
//
// One sample is taken per cycle while req_tready is high. An accepted beat passes
// through the five register stages (cross product, difference, matrix products, row
// sums, scale and clamp) to the output register, where it can be taken.
// Reset clears all stage valid bits and loads the identity rotation and zero offset.
// A stall on rsp holds an occupied stage only while every stage after it is occupied;
// beats move up into empty stages, so req_tready stays high until all five hold a beat.
// A register write reaches the rotation matrix through the product and matrix registers,
// which is ahead of the third stage where a beat accepted after the write first uses it.
module wrench_frame_transform (
   input  logic                          clock,
   input  logic                          reset,
   // Input sample stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // From bit 0: force_x, force_y, force_z, torque_x, torque_y, torque_z.
   input  logic [wft_pkg::TDATA_W-1:0]   req_tdata,
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // From bit 0: out_force_x, out_force_y, out_force_z,
   // out_torque_x, out_torque_y, out_torque_z.
   output logic [wft_pkg::TDATA_W-1:0]   rsp_tdata,
   // Register write port.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wft_pkg::FIELD_W-1:0]   csr_data
);
   import wft_pkg::*;

   localparam int STAGES = 5;

   // Frame registers: quaternion in Q2.30 and offset in Q16.16.
   field_type rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   field_type pos_x_ff, pos_y_ff, pos_z_ff;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;
   adv_type           adv;

   field_type force_in  [3];
   field_type torque_in [3];
   field_type pos       [3];
   coef_type  mat       [3][3];
   vhi_type   f_hi [3];
   vlo_type   f_lo [3];
   vhi_type   t_hi [3];
   vlo_type   t_lo [3];
   field_type f_res [3];
   field_type t_res [3];

   // The write port never pushes back; a write to an unused index is dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= ROT_ONE;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROT_W: rot_w_ff <= csr_data;
            REG_ROT_X: rot_x_ff <= csr_data;
            REG_ROT_Y: rot_y_ff <= csr_data;
            REG_ROT_Z: rot_z_ff <= csr_data;
            REG_POS_X: pos_x_ff <= csr_data;
            REG_POS_Y: pos_y_ff <= csr_data;
            REG_POS_Z: pos_z_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it can load.
   // The payload of every stage loads on the same condition as its valid bit.
   always_comb begin
      rdy[STAGES-1] = ~valid_ff[STAGES-1] | rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = ~valid_ff[i] | rdy[i+1];
      end
      valid_in[0] = rdy[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign adv.s1 = rdy[0];
   assign adv.s2 = rdy[1];
   assign adv.s3 = rdy[2];
   assign adv.s4 = rdy[3];
   assign adv.s5 = rdy[4];

   assign req_tready = rdy[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         force_in[i]  = req_tdata[i*FIELD_W +: FIELD_W];
         torque_in[i] = req_tdata[(i+3)*FIELD_W +: FIELD_W];
      end
   end

   assign pos[0] = pos_x_ff;
   assign pos[1] = pos_y_ff;
   assign pos[2] = pos_z_ff;

   wft_coef u_coef (
      .clock (clock),
      .rot_w (rot_w_ff),
      .rot_x (rot_x_ff),
      .rot_y (rot_y_ff),
      .rot_z (rot_z_ff),
      .mat   (mat)
   );

   wft_front u_front (
      .clock     (clock),
      .adv       (adv),
      .force_in  (force_in),
      .torque_in (torque_in),
      .pos       (pos),
      .f_hi      (f_hi),
      .f_lo      (f_lo),
      .t_hi      (t_hi),
      .t_lo      (t_lo)
   );

   // The force and the shifted torque go through identical rotation units.
   wft_rotate u_rot_force (
      .clock (clock),
      .adv   (adv),
      .mat   (mat),
      .v_hi  (f_hi),
      .v_lo  (f_lo),
      .res   (f_res)
   );

   wft_rotate u_rot_torque (
      .clock (clock),
      .adv   (adv),
      .mat   (mat),
      .v_hi  (t_hi),
      .v_lo  (t_lo),
      .res   (t_res)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[i*FIELD_W +: FIELD_W]     = f_res[i];
         rsp_tdata[(i+3)*FIELD_W +: FIELD_W] = t_res[i];
      end
   end

endmodule

@@ hdl/wft_coef.sv @@
`timescale 1ns / 1ps
// Rotation matrix builder: quaternion component products, then R(q) transposed.
// Depends on wft_pkg.
module wft_coef (
   input  logic               clock,
   input  wft_pkg::field_type rot_w,
   input  wft_pkg::field_type rot_x,
   input  wft_pkg::field_type rot_y,
   input  wft_pkg::field_type rot_z,
   output wft_pkg::coef_type  mat [3][3]
);
   import wft_pkg::*;

   localparam int QP_W = 2 * FIELD_W - 30;

   typedef logic signed [QP_W-1:0] qp_type;

   function automatic qp_type qprod(input field_type a, input field_type b);
      logic signed [2*FIELD_W-1:0] p;
      p = a * b;
      return p[2*FIELD_W-1:30];
   endfunction

   function automatic coef_type cx(input qp_type v);
      return {{(COEF_W-QP_W){v[QP_W-1]}}, v};
   endfunction

   qp_type   ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   coef_type mat_ff [3][3];
   coef_type mat_in [3][3];

   // The products follow the registers freely; a write reaches the matrix through the
   // product registers and then the matrix register.
   always_ff @(posedge clock) begin
      ww_ff <= qprod(rot_w, rot_w);
      xx_ff <= qprod(rot_x, rot_x);
      yy_ff <= qprod(rot_y, rot_y);
      zz_ff <= qprod(rot_z, rot_z);
      xy_ff <= qprod(rot_x, rot_y);
      xz_ff <= qprod(rot_x, rot_z);
      yz_ff <= qprod(rot_y, rot_z);
      wx_ff <= qprod(rot_w, rot_x);
      wy_ff <= qprod(rot_w, rot_y);
      wz_ff <= qprod(rot_w, rot_z);
   end

   always_comb begin
      mat_in[0][0] = cx(ww_ff) + cx(xx_ff) - cx(yy_ff) - cx(zz_ff);
      mat_in[0][1] = (cx(xy_ff) + cx(wz_ff)) <<< 1;
      mat_in[0][2] = (cx(xz_ff) - cx(wy_ff)) <<< 1;
      mat_in[1][0] = (cx(xy_ff) - cx(wz_ff)) <<< 1;
      mat_in[1][1] = cx(ww_ff) - cx(xx_ff) + cx(yy_ff) - cx(zz_ff);
      mat_in[1][2] = (cx(yz_ff) + cx(wx_ff)) <<< 1;
      mat_in[2][0] = (cx(xz_ff) + cx(wy_ff)) <<< 1;
      mat_in[2][1] = (cx(yz_ff) - cx(wx_ff)) <<< 1;
      mat_in[2][2] = cx(ww_ff) - cx(xx_ff) - cx(yy_ff) + cx(zz_ff);
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign mat = mat_ff;

endmodule

@@ hdl/wft_front.sv @@
`timescale 1ns / 1ps
// Front stages: lever-arm cross product, torque difference and vector split.
// Depends on wft_pkg.
module wft_front (
   input  logic               clock,
   input  wft_pkg::adv_type   adv,
   input  wft_pkg::field_type force_in  [3],
   input  wft_pkg::field_type torque_in [3],
   input  wft_pkg::field_type pos       [3],
   output wft_pkg::vhi_type   f_hi [3],
   output wft_pkg::vlo_type   f_lo [3],
   output wft_pkg::vhi_type   t_hi [3],
   output wft_pkg::vlo_type   t_lo [3]
);
   import wft_pkg::*;

   localparam int XP_W = 2 * FIELD_W - 16;

   typedef logic signed [XP_W-1:0]  xp_type;
   typedef logic signed [VEC_W-1:0] vec_type;

   field_type f1_ff [3];
   field_type t1_ff [3];
   xp_type    pa_ff [3];
   xp_type    pb_ff [3];
   xp_type    pa_in [3];
   xp_type    pb_in [3];
   vec_type   fv [3];
   vec_type   dv [3];
   vhi_type   f_hi_ff [3];
   vlo_type   f_lo_ff [3];
   vhi_type   t_hi_ff [3];
   vlo_type   t_lo_ff [3];

   // Component i of p x f is pos[j]*f[k] - pos[k]*f[j], each term floored.
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [2*FIELD_W-1:0] prod_a, prod_b;
      assign prod_a   = pos[J] * force_in[K];
      assign prod_b   = pos[K] * force_in[J];
      assign pa_in[i] = prod_a[2*FIELD_W-1:16];
      assign pb_in[i] = prod_b[2*FIELD_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         f1_ff <= force_in;
         t1_ff <= torque_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fv[i] = {{(VEC_W-FIELD_W){f1_ff[i][FIELD_W-1]}}, f1_ff[i]};
         dv[i] = {{(VEC_W-FIELD_W){t1_ff[i][FIELD_W-1]}}, t1_ff[i]}
               - ({{(VEC_W-XP_W){pa_ff[i][XP_W-1]}}, pa_ff[i]}
                - {{(VEC_W-XP_W){pb_ff[i][XP_W-1]}}, pb_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         for (int i = 0; i < 3; i++) begin
            f_hi_ff[i] <= fv[i][VEC_W-1:SPLIT];
            f_lo_ff[i] <= fv[i][SPLIT-1:0];
            t_hi_ff[i] <= dv[i][VEC_W-1:SPLIT];
            t_lo_ff[i] <= dv[i][SPLIT-1:0];
         end
      end
   end

   assign f_hi = f_hi_ff;
   assign f_lo = f_lo_ff;
   assign t_hi = t_hi_ff;
   assign t_lo = t_lo_ff;

endmodule

@@ hdl/wft_rotate.sv @@
`timescale 1ns / 1ps
// Three-stage matrix-vector rotation with floor scaling and 32-bit saturation.
// Depends on wft_pkg.
module wft_rotate (
   input  logic               clock,
   input  wft_pkg::adv_type   adv,
   input  wft_pkg::coef_type  mat  [3][3],
   input  wft_pkg::vhi_type   v_hi [3],
   input  wft_pkg::vlo_type   v_lo [3],
   output wft_pkg::field_type res  [3]
);
   import wft_pkg::*;

   localparam int PP_W = COEF_W + VH_W;
   localparam int ACC_W = PP_W + 2;
   localparam int LO_W = ACC_W - SPLIT;
   localparam int DROP = 30 - SPLIT;
   localparam int TOP = DROP + FIELD_W - 1;

   typedef logic signed [PP_W-1:0]  pp_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [LO_W-1:0]  lo_type;

   function automatic acc_type ext_acc(input pp_type v);
      return {{(ACC_W-PP_W){v[PP_W-1]}}, v};
   endfunction

   pp_type    hp_ff [3][3];
   pp_type    lp_ff [3][3];
   pp_type    hp_in [3][3];
   pp_type    lp_in [3][3];
   acc_type   hi_ff [3];
   lo_type    lo_ff [3];
   acc_type   hi_in [3];
   lo_type    lo_in [3];
   field_type res_ff [3];
   field_type res_in [3];

   // Stage 3: the vector is split at bit 24 so that each product stays narrow.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            hp_in[i][j] = mat[i][j] * v_hi[j];
            lp_in[i][j] = mat[i][j] * $signed({1'b0, v_lo[j]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         hp_ff <= hp_in;
         lp_ff <= lp_in;
      end
   end

   // Stage 4: row sums; the low half is floored down to the high half's weight.
   always_comb begin
      acc_type lo_sum;
      for (int i = 0; i < 3; i++) begin
         hi_in[i] = ext_acc(hp_ff[i][0]) + ext_acc(hp_ff[i][1]) + ext_acc(hp_ff[i][2]);
         lo_sum   = ext_acc(lp_ff[i][0]) + ext_acc(lp_ff[i][1]) + ext_acc(lp_ff[i][2]);
         lo_in[i] = lo_sum[ACC_W-1:SPLIT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   // Stage 5: join the halves, drop six more bits and clamp to 32 bits.
   always_comb begin
      acc_type total;
      logic    fits;
      for (int i = 0; i < 3; i++) begin
         total = hi_ff[i] + {{SPLIT{lo_ff[i][LO_W-1]}}, lo_ff[i]};
         fits  = (&total[ACC_W-1:TOP]) | ~(|total[ACC_W-1:TOP]);
         if (fits) begin
            res_in[i] = total[TOP:DROP];
         end else if (total[ACC_W-1]) begin
            res_in[i] = {1'b1, {(FIELD_W-1){1'b0}}};
         end else begin
            res_in[i] = {1'b0, {(FIELD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

@@ hdl/wft_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the wrench frame transform, bound to the top level.
// Depends on wft_pkg and wrench_frame_transform_macros.svh.
`include "wrench_frame_transform_macros.svh"

module wft_port_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [wft_pkg::TDATA_W-1:0]   req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [wft_pkg::TDATA_W-1:0]   rsp_tdata,
   input logic                          csr_valid,
   input logic                          csr_ready
);
   import wft_pkg::*;

   property p_rsp_hold;
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata));
   endproperty

   property p_zero_latency;
      (req_tvalid && req_tready && (req_tdata == '0))
         ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
         |=> (rsp_tvalid && (rsp_tdata == '0) && csr_ready);
   endproperty

   // A held result keeps its beat.
   `WFT_ASSERT(a_rsp_hold, p_rsp_hold, "rsp beat changed while stalled")

   // The pipeline never pushes back while the result side drains.
   `WFT_ASSERT(a_no_bubble, rsp_tready |-> req_tready, "req_tready low while rsp_tready high")

   // The register port takes every write at once.
   `WFT_ASSERT(a_csr_ready, csr_valid |-> csr_ready, "csr write pushed back")

   // A zero wrench maps to a zero wrench when rsp_tready stays high after it is accepted.
   `WFT_ASSERT(a_zero_latency, p_zero_latency, "zero sample gave a wrong or late result")

   // Reset empties the pipeline.
   `WFT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind wrench_frame_transform wft_port_props u_wft_port_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
